FILE: hw/rtl/cap_pkg.sv
// Shared types and constants for the cascaded attitude PID axis core.
// Used by the register bank, the controller and the datapath; no dependencies.
package cap_pkg;

  localparam int SIG_W   = 24;   // Q7.16 signal and gain width
  localparam int LIM_W   = 23;   // unsigned limit register width
  localparam int SUM_W   = 32;   // integrator width
  localparam int MUL_B_W = 32;   // wide operand of the shared multiplier
  localparam int PROD_W  = SIG_W + MUL_B_W;
  localparam int ACC_W   = 60;
  localparam int FRAC_W  = 16;
  localparam int IDX_W   = 4;

  typedef enum logic [IDX_W-1:0] {
    REG_ANGLE_LIMIT   = 4'd0,
    REG_ANGLE_P_GAIN  = 4'd1,
    REG_ANGLE_FF_GAIN = 4'd2,
    REG_RATE_LIMIT    = 4'd3,
    REG_RATE_P_GAIN   = 4'd4,
    REG_RATE_I_GAIN   = 4'd5,
    REG_RATE_D_GAIN   = 4'd6,
    REG_RATE_FF_GAIN  = 4'd7
  } reg_idx_t;

  localparam logic [LIM_W-1:0] RST_ANGLE_LIMIT   = 23'd40023;
  localparam logic [SIG_W-1:0] RST_ANGLE_P_GAIN  = 24'd367002;
  localparam logic [SIG_W-1:0] RST_ANGLE_FF_GAIN = 24'd6554;
  localparam logic [LIM_W-1:0] RST_RATE_LIMIT    = 23'd251648;
  localparam logic [SIG_W-1:0] RST_RATE_P_GAIN   = 24'd9830;
  localparam logic [SIG_W-1:0] RST_RATE_I_GAIN   = 24'd7;
  localparam logic [SIG_W-1:0] RST_RATE_D_GAIN   = 24'd7;
  localparam logic [SIG_W-1:0] RST_RATE_FF_GAIN  = 24'd32768;

  typedef struct packed {
    logic        [LIM_W-1:0] angle_limit;
    logic signed [SIG_W-1:0] angle_p_gain;
    logic signed [SIG_W-1:0] angle_ff_gain;
    logic        [LIM_W-1:0] rate_limit;
    logic signed [SIG_W-1:0] rate_p_gain;
    logic signed [SIG_W-1:0] rate_i_gain;
    logic signed [SIG_W-1:0] rate_d_gain;
    logic signed [SIG_W-1:0] rate_ff_gain;
  } cfg_regs_t;

  typedef enum logic [2:0] {
    MUL_ANGLE_P  = 3'd0,
    MUL_ANGLE_FF = 3'd1,
    MUL_RATE_P   = 3'd2,
    MUL_RATE_I   = 3'd3,
    MUL_RATE_D   = 3'd4,
    MUL_RATE_FF  = 3'd5
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD = 2'd0,
    ACC_LOAD = 2'd1,
    ACC_ADD  = 2'd2
  } acc_op_t;

  typedef struct packed {
    logic     capture;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     dr_load;
    logic     err_load;
    logic     integ_load;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_status_t;

endpackage

FILE: hw/rtl/cap_regs.sv
// Configuration register bank for the attitude PID axis core.
// Depends on cap_pkg for the register index codes, reset values and cfg_regs_t.
module cap_regs
  import cap_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [IDX_W-1:0]     cfg_index,
  input  logic [SIG_W-1:0]     cfg_data,
  output cfg_regs_t            cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.angle_limit   <= RST_ANGLE_LIMIT;
      cfg.angle_p_gain  <= RST_ANGLE_P_GAIN;
      cfg.angle_ff_gain <= RST_ANGLE_FF_GAIN;
      cfg.rate_limit    <= RST_RATE_LIMIT;
      cfg.rate_p_gain   <= RST_RATE_P_GAIN;
      cfg.rate_i_gain   <= RST_RATE_I_GAIN;
      cfg.rate_d_gain   <= RST_RATE_D_GAIN;
      cfg.rate_ff_gain  <= RST_RATE_FF_GAIN;
    end else if (cfg_valid && cfg_ready) begin
      // Indexes past the last register are dropped.
      unique case (reg_idx_t'(cfg_index))
        REG_ANGLE_LIMIT:   cfg.angle_limit   <= cfg_data[LIM_W-1:0];
        REG_ANGLE_P_GAIN:  cfg.angle_p_gain  <= cfg_data;
        REG_ANGLE_FF_GAIN: cfg.angle_ff_gain <= cfg_data;
        REG_RATE_LIMIT:    cfg.rate_limit    <= cfg_data[LIM_W-1:0];
        REG_RATE_P_GAIN:   cfg.rate_p_gain   <= cfg_data;
        REG_RATE_I_GAIN:   cfg.rate_i_gain   <= cfg_data;
        REG_RATE_D_GAIN:   cfg.rate_d_gain   <= cfg_data;
        REG_RATE_FF_GAIN:  cfg.rate_ff_gain  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

FILE: hw/rtl/cap_ctrl.sv
// Sequencing state machine for the attitude PID axis core.
// Depends on cap_pkg for the command and status structs it exchanges with cap_dp.
module cap_ctrl
  import cap_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [11:0] {
    ST_IDLE      = 12'b0000_0000_0001,
    ST_OUTER_P   = 12'b0000_0000_0010,
    ST_OUTER_FF  = 12'b0000_0000_0100,
    ST_OUTER_SUM = 12'b0000_0000_1000,
    ST_RATE      = 12'b0000_0001_0000,
    ST_ERROR     = 12'b0000_0010_0000,
    ST_INNER_P   = 12'b0000_0100_0000,
    ST_INNER_I   = 12'b0000_1000_0000,
    ST_INNER_D   = 12'b0001_0000_0000,
    ST_INNER_FF  = 12'b0010_0000_0000,
    ST_INNER_SUM = 12'b0100_0000_0000,
    ST_RESULT    = 12'b1000_0000_0000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.mul_sel    = MUL_ANGLE_P;
    cmd.acc_op     = ACC_HOLD;
    unique case (state)
      ST_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid) state_next = ST_OUTER_P;
      end
      ST_OUTER_P: begin
        cmd.mul_sel = MUL_ANGLE_P;
        state_next  = ST_OUTER_FF;
      end
      ST_OUTER_FF: begin
        cmd.mul_sel = MUL_ANGLE_FF;
        cmd.acc_op  = ACC_LOAD;
        state_next  = ST_OUTER_SUM;
      end
      ST_OUTER_SUM: begin
        cmd.acc_op = ACC_ADD;
        state_next = ST_RATE;
      end
      ST_RATE: begin
        cmd.dr_load = 1'b1;
        state_next  = ST_ERROR;
      end
      ST_ERROR: begin
        cmd.err_load = 1'b1;
        state_next   = ST_INNER_P;
      end
      ST_INNER_P: begin
        cmd.mul_sel    = MUL_RATE_P;
        cmd.integ_load = 1'b1;
        state_next     = ST_INNER_I;
      end
      ST_INNER_I: begin
        cmd.mul_sel = MUL_RATE_I;
        cmd.acc_op  = ACC_LOAD;
        state_next  = ST_INNER_D;
      end
      ST_INNER_D: begin
        cmd.mul_sel = MUL_RATE_D;
        cmd.acc_op  = ACC_ADD;
        state_next  = ST_INNER_FF;
      end
      ST_INNER_FF: begin
        cmd.mul_sel = MUL_RATE_FF;
        cmd.acc_op  = ACC_ADD;
        state_next  = ST_INNER_SUM;
      end
      ST_INNER_SUM: begin
        cmd.acc_op = ACC_ADD;
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        // Hold here until the output register has room.
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

FILE: hw/rtl/cap_dp.sv
// Datapath for the attitude PID axis core: operand registers, one shared
// multiplier, accumulator, saturation logic and output register. Depends on cap_pkg.
module cap_dp
  import cap_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  cfg_regs_t               cfg,
  input  dp_cmd_t                 cmd,
  output dp_status_t              status,
  input  logic signed [SIG_W-1:0] desired_angle,
  input  logic signed [SIG_W-1:0] measured_angle,
  input  logic signed [SIG_W-1:0] measured_rate,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [SIG_W-1:0] drive_value
);

  localparam int SHR_W = ACC_W - FRAC_W;
  localparam logic signed [SHR_W-1:0] SHR_S24_MIN = {{(SHR_W-SIG_W+1){1'b1}}, {(SIG_W-1){1'b0}}};
  localparam logic signed [SHR_W-1:0] SHR_S24_MAX = {{(SHR_W-SIG_W+1){1'b0}}, {(SIG_W-1){1'b1}}};
  localparam logic signed [SIG_W-1:0] S24_MIN = {1'b1, {(SIG_W-1){1'b0}}};
  localparam logic signed [SIG_W-1:0] S24_MAX = {1'b0, {(SIG_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] S32_MIN = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic signed [SUM_W-1:0] S32_MAX = {1'b0, {(SUM_W-1){1'b1}}};

  logic signed [SIG_W-1:0]   da;
  logic signed [SIG_W-1:0]   ma;
  logic signed [SIG_W-1:0]   mr;
  logic signed [SIG_W-1:0]   dr;
  logic signed [SIG_W-1:0]   err;
  logic signed [SIG_W:0]     err_diff;
  logic signed [SUM_W-1:0]   rate_error_sum;
  logic signed [SIG_W-1:0]   last_rate_error;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc;

  logic signed [SIG_W-1:0]   da_clamped;
  logic signed [SIG_W:0]     angle_err;
  logic signed [SIG_W-1:0]   mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [ACC_W-1:0]   prod_ext;
  logic signed [SHR_W-1:0]   acc_shr;
  logic signed [SIG_W-1:0]   dr_value;
  logic signed [SIG_W:0]     err_raw;
  logic signed [SIG_W-1:0]   err_value;
  logic signed [SUM_W:0]     sum_raw;
  logic signed [SUM_W-1:0]   sum_value;
  logic signed [SIG_W-1:0]   out_value;

  assign status.out_busy = out_valid && !out_ready;

  // Desired angle has an upper clamp only.
  assign da_clamped = (desired_angle > $signed({1'b0, cfg.angle_limit}))
                    ? $signed({1'b0, cfg.angle_limit}) : desired_angle;

  assign angle_err = {da[SIG_W-1], da} - {ma[SIG_W-1], ma};

  always_comb begin
    mul_a = cfg.angle_p_gain;
    mul_b = MUL_B_W'(angle_err);
    case (cmd.mul_sel)
      MUL_ANGLE_P: begin
        mul_a = cfg.angle_p_gain;
        mul_b = MUL_B_W'(angle_err);
      end
      MUL_ANGLE_FF: begin
        mul_a = cfg.angle_ff_gain;
        mul_b = MUL_B_W'(da);
      end
      MUL_RATE_P: begin
        mul_a = cfg.rate_p_gain;
        mul_b = MUL_B_W'(err);
      end
      MUL_RATE_I: begin
        mul_a = cfg.rate_i_gain;
        mul_b = rate_error_sum;
      end
      MUL_RATE_D: begin
        mul_a = cfg.rate_d_gain;
        mul_b = MUL_B_W'(err_diff);
      end
      MUL_RATE_FF: begin
        mul_a = cfg.rate_ff_gain;
        mul_b = MUL_B_W'(dr);
      end
      default: ;
    endcase
  end

  assign prod_ext = ACC_W'(prod);

  // The arithmetic shift of the accumulator is a floor division by 2^16.
  assign acc_shr = acc[ACC_W-1:FRAC_W];

  always_comb begin
    if (acc_shr > $signed({{(SHR_W-LIM_W){1'b0}}, cfg.rate_limit})) begin
      dr_value = $signed({1'b0, cfg.rate_limit});
    end else if (acc_shr < SHR_S24_MIN) begin
      dr_value = S24_MIN;
    end else begin
      dr_value = acc_shr[SIG_W-1:0];
    end
  end

  assign err_raw = {dr[SIG_W-1], dr} - {mr[SIG_W-1], mr};
  always_comb begin
    if (err_raw[SIG_W] != err_raw[SIG_W-1]) begin
      err_value = err_raw[SIG_W] ? S24_MIN : S24_MAX;
    end else begin
      err_value = err_raw[SIG_W-1:0];
    end
  end

  assign sum_raw = {rate_error_sum[SUM_W-1], rate_error_sum} + (SUM_W+1)'(err);
  always_comb begin
    if (sum_raw[SUM_W] != sum_raw[SUM_W-1]) begin
      sum_value = sum_raw[SUM_W] ? S32_MIN : S32_MAX;
    end else begin
      sum_value = sum_raw[SUM_W-1:0];
    end
  end

  always_comb begin
    if (acc_shr > SHR_S24_MAX) begin
      out_value = S24_MAX;
    end else if (acc_shr < SHR_S24_MIN) begin
      out_value = S24_MIN;
    end else begin
      out_value = acc_shr[SIG_W-1:0];
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (cmd.capture) begin
      da <= da_clamped;
      ma <= measured_angle;
      mr <= measured_rate;
    end
    case (cmd.acc_op)
      ACC_LOAD: acc <= prod_ext;
      ACC_ADD:  acc <= acc + prod_ext;
      default:  ;
    endcase
    if (cmd.dr_load)    dr       <= dr_value;
    if (cmd.err_load)   err      <= err_value;
    if (cmd.integ_load) err_diff <= {err[SIG_W-1], err} - {last_rate_error[SIG_W-1], last_rate_error};
    if (cmd.out_load)   drive_value <= out_value;
  end

  // Controller state carried from sample to sample, and the output flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      rate_error_sum  <= '0;
      last_rate_error <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cmd.integ_load) begin
        rate_error_sum  <= sum_value;
        last_rate_error <= err;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: hw/rtl/cascaded_attitude_pid_axis_core.sv
// Top level of one attitude axis of a cascaded P / PID attitude controller.
// Instantiates cap_regs, cap_ctrl and cap_dp; depends on cap_pkg.
//
//   Channel  Direction  Handshake             Payload
//   in       sink       in_valid / in_ready   desired_angle, measured_angle, measured_rate
//   out      source     out_valid / out_ready drive_value
//   cfg      sink       cfg_valid / cfg_ready cfg_index (4 bits), cfg_data (24 bits)
//
// Each input steps the controller through its states in order: the result is
// loaded into the output register in the last state, and the next input is
// taken once the controller is idle again. The shared 24 x 32 multiplier serves
// the six gain products in turn; clamp, error and integrator steps lie between.
// Synchronous active-high reset restores the register defaults and clears the
// integrator, the previous rate error and the output valid flag.
// A stalled output holds its value; one further input may be accepted and
// worked on meanwhile, and its result waits in the last step for the slot.
//
// Sample flow: the desired angle is clamped from above, the outer stage forms
// the desired rate from a P term and an angle feedforward term, clamps it from
// above and saturates it to 24 bits. The inner stage forms the saturated rate
// error, updates the saturating 32-bit integrator, and sums P, I, D and rate
// feedforward products at full precision before a floor shift by 16 and a
// saturation to 24 bits. Configuration writes are always accepted; writes to
// indexes beyond the last register are dropped.
module cascaded_attitude_pid_axis_core
  import cap_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [SIG_W-1:0] desired_angle,
  input  logic signed [SIG_W-1:0] measured_angle,
  input  logic signed [SIG_W-1:0] measured_rate,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [SIG_W-1:0] drive_value,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [IDX_W-1:0]        cfg_index,
  input  logic [SIG_W-1:0]        cfg_data
);

  cfg_regs_t  cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  // Register bank written through the configuration channel.
  cap_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The controller steps through the sample and issues one command word a cycle.
  cap_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the operands, the shared multiplier and the state.
  cap_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .cmd            (cmd),
    .status         (status),
    .desired_angle  (desired_angle),
    .measured_angle (measured_angle),
    .measured_rate  (measured_rate),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .drive_value    (drive_value)
  );

endmodule

FILE: hw/rtl/cap_checker.sv
// Port-level checks for the attitude PID axis core, bound to the top level.
// Depends on cap_pkg for the signal width.
module cap_checker
  import cap_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [SIG_W-1:0] drive_value
);

  // Transactions accepted at the input and not yet delivered.
  logic [1:0] pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted on the cycle after an accepted transaction");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(drive_value)))
    else $error("stalled result dropped or changed");

  a_no_spurious_out: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready) |-> (pending != 2'd0))
    else $error("result delivered with no transaction outstanding");

  a_idle_no_out: assert property (@(posedge clk) disable iff (rst)
    (pending == 2'd0) |-> !out_valid)
    else $error("output valid with nothing outstanding");

  a_two_deep: assert property (@(posedge clk) disable iff (rst)
    (pending == 2'd2) |-> !in_ready)
    else $error("third transaction could be accepted");

endmodule

bind cascaded_attitude_pid_axis_core cap_checker u_cap_checker (.*);

FILE: sim/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for cascaded_attitude_pid_axis_core: a scoreboard class
// predicts each drive value, plain tasks drive the sample and register channels,
// and a process drives out_ready. Depends on cap_pkg and the core RTL only.

import cap_pkg::*;

// Predicts the drive value of every accepted sample from its own copy of the gain
// registers, the error integrator and the previous rate error. The expected drive
// values wait in a FIFO until the core presents its results.
class drive_scoreboard;
  localparam longint SIG_HI = (64'sd1 <<< (SIG_W - 1)) - 1;
  localparam longint SIG_LO = -(64'sd1 <<< (SIG_W - 1));
  localparam longint SUM_HI = (64'sd1 <<< (SUM_W - 1)) - 1;
  localparam longint SUM_LO = -(64'sd1 <<< (SUM_W - 1));
  localparam int unsigned MAX_SHOWN = 10;

  cfg_regs_t               cfg;
  logic signed [SUM_W-1:0] error_sum;
  logic signed [SIG_W-1:0] last_error;
  logic signed [SIG_W-1:0] expected_drive[$];
  int unsigned             mismatches;

  function new();
    cfg.angle_limit   = RST_ANGLE_LIMIT;
    cfg.angle_p_gain  = RST_ANGLE_P_GAIN;
    cfg.angle_ff_gain = RST_ANGLE_FF_GAIN;
    cfg.rate_limit    = RST_RATE_LIMIT;
    cfg.rate_p_gain   = RST_RATE_P_GAIN;
    cfg.rate_i_gain   = RST_RATE_I_GAIN;
    cfg.rate_d_gain   = RST_RATE_D_GAIN;
    cfg.rate_ff_gain  = RST_RATE_FF_GAIN;
    error_sum  = '0;
    last_error = '0;
    mismatches = 0;
  endfunction

  function longint clip(longint x, longint lo, longint hi);
    if (x > hi) return hi;
    if (x < lo) return lo;
    return x;
  endfunction

  function void report(string msg);
    mismatches++;
    if (mismatches <= MAX_SHOWN) $display("%s", msg);
  endfunction

  // Limits keep only their low LIM_W bits; indexes past the last register are dropped.
  function void write_reg(logic [IDX_W-1:0] idx, logic [SIG_W-1:0] data);
    case (idx)
      REG_ANGLE_LIMIT:   cfg.angle_limit   = data[LIM_W-1:0];
      REG_ANGLE_P_GAIN:  cfg.angle_p_gain  = data;
      REG_ANGLE_FF_GAIN: cfg.angle_ff_gain = data;
      REG_RATE_LIMIT:    cfg.rate_limit    = data[LIM_W-1:0];
      REG_RATE_P_GAIN:   cfg.rate_p_gain   = data;
      REG_RATE_I_GAIN:   cfg.rate_i_gain   = data;
      REG_RATE_D_GAIN:   cfg.rate_d_gain   = data;
      REG_RATE_FF_GAIN:  cfg.rate_ff_gain  = data;
      default: ;
    endcase
  endfunction

  function void note_sample(logic signed [SIG_W-1:0] cmd_angle,
                            logic signed [SIG_W-1:0] meas_angle,
                            logic signed [SIG_W-1:0] meas_rate);
    longint da, ma, mr, a_lim, r_lim;
    longint a_p, a_ff, r_p, r_i, r_d, r_ff;
    longint dr, err, prev_err, sum, acc;
    da    = cmd_angle;
    ma    = meas_angle;
    mr    = meas_rate;
    a_lim = cfg.angle_limit;
    r_lim = cfg.rate_limit;
    a_p   = $signed(cfg.angle_p_gain);
    a_ff  = $signed(cfg.angle_ff_gain);
    r_p   = $signed(cfg.rate_p_gain);
    r_i   = $signed(cfg.rate_i_gain);
    r_d   = $signed(cfg.rate_d_gain);
    r_ff  = $signed(cfg.rate_ff_gain);

    // Outer loop: clamp the command, then P plus feedforward gives the rate demand.
    if (da > a_lim) da = a_lim;
    dr = (a_p * (da - ma) + a_ff * da) >>> FRAC_W;
    if (dr > r_lim) dr = r_lim;
    dr = clip(dr, SIG_LO, SIG_HI);

    // Inner loop on the saturated rate error.
    err       = clip(dr - mr, SIG_LO, SIG_HI);
    sum       = error_sum;
    sum       = clip(sum + err, SUM_LO, SUM_HI);
    error_sum = SUM_W'(sum);
    prev_err  = last_error;
    acc       = r_p * err + r_i * sum + r_d * (err - prev_err) + r_ff * dr;
    expected_drive.push_back(SIG_W'(clip(acc >>> FRAC_W, SIG_LO, SIG_HI)));
    last_error = SIG_W'(err);
  endfunction

  function void check_result(logic signed [SIG_W-1:0] got);
    logic signed [SIG_W-1:0] want;
    if (expected_drive.size() == 0) begin
      report($sformatf("drive_value %0d arrived with no sample outstanding", got));
      return;
    end
    want = expected_drive.pop_front();
    if (got !== want)
      report($sformatf("drive_value mismatch: expected %0d, got %0d", want, got));
  endfunction

  function int unsigned pending();
    return expected_drive.size();
  endfunction

  function void close();
    if (expected_drive.size() != 0)
      report($sformatf("%0d drive values never arrived", expected_drive.size()));
  endfunction
endclass

module tb;
  localparam int CLK_PERIOD = 10;
  // Span of one sample's work in the core; used for the quiet time at the end.
  localparam int ITEM_CYCLES = 12;
  // Slowest legal run: about 1720 samples, each with the longest input gap, the
  // core's work and the longest output stall. Register writes add little.
  // The limit is several times the length of that run.
  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam int REG_COUNT = int'(REG_RATE_FF_GAIN) + 1;
  localparam int SIG_TOP_I = 2 ** (SIG_W - 1) - 1;
  localparam int SIG_BOT_I = -(2 ** (SIG_W - 1));
  localparam logic signed [SIG_W-1:0] SIG_TOP = {1'b0, {(SIG_W - 1){1'b1}}};
  localparam logic signed [SIG_W-1:0] SIG_BOT = {1'b1, {(SIG_W - 1){1'b0}}};
  localparam logic [LIM_W-1:0] LIM_TOP = '1;

  // Each test phase picks a register setting and a matching shape of samples.
  typedef enum int {
    PH_TYPICAL,    // moderate gains, samples near zero, some wide noise
    PH_WIDE,       // random registers and random samples over the full range
    PH_MAX,        // all gains and limits at their largest
    PH_MIN,        // all gains at their most negative, limits at zero
    PH_ZERO,       // all registers zero, samples random
    PH_PUSH_UP,    // rate demand pinned high, rate error saturates positive
    PH_PUSH_DOWN   // rate demand pinned low, rate error saturates negative
  } phase_kind_t;

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    in_valid;
  logic                    in_ready;
  logic signed [SIG_W-1:0] desired_angle;
  logic signed [SIG_W-1:0] measured_angle;
  logic signed [SIG_W-1:0] measured_rate;
  logic                    out_valid;
  logic                    out_ready;
  logic signed [SIG_W-1:0] drive_value;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [IDX_W-1:0]        cfg_index;
  logic [SIG_W-1:0]        cfg_data;

  drive_scoreboard drive_check;
  int unsigned     cycles = 0;
  // When set, that side runs a phase back to back with no idle cycles.
  bit              in_burst  = 1'b0;
  bit              out_burst = 1'b0;

  cascaded_attitude_pid_axis_core i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .desired_angle  (desired_angle),
    .measured_angle (measured_angle),
    .measured_rate  (measured_rate),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .drive_value    (drive_value),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Every output transaction is compared against the oldest prediction. All
  // drives are nonblocking, so the values seen here are the ones of the edge.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) drive_check.check_result(drive_value);
  end

  // Result side. For most results the receiver first sees out_valid, then
  // holds ready low for a randomly drawn stall, which lets the core take the
  // next sample while the current result waits. A zero draw (and every
  // result of a burst phase) keeps ready high straight through.
  initial begin : result_side
    int unsigned stall;
    out_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = out_burst ? 0 : $urandom_range(0, 7);
      if (stall != 0) begin
        out_ready <= 1'b0;
        do @(posedge clk); while (!out_valid);
        repeat (stall - 1) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  function automatic logic signed [SIG_W-1:0] any_sig();
    return SIG_W'($urandom);
  endfunction

  // Uniform in [-span, span].
  function automatic logic signed [SIG_W-1:0] near_sig(int unsigned span);
    return SIG_W'(int'($urandom_range(0, 2 * span)) - int'(span));
  endfunction

  // Uniform in [lo, hi].
  function automatic logic signed [SIG_W-1:0] between(int lo, int hi);
    return SIG_W'(lo + int'($urandom_range(0, hi - lo)));
  endfunction

  // One register write transaction. cfg_valid stays high so that writes can
  // follow back to back; the caller lowers it after the last one.
  task automatic write_reg(logic [IDX_W-1:0] idx, logic [SIG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    drive_check.write_reg(idx, data);
  endtask

  // One sample transaction, preceded by a random idle gap. in_valid is only
  // lowered when a gap is actually taken.
  task automatic send_sample(logic signed [SIG_W-1:0] da,
                             logic signed [SIG_W-1:0] ma,
                             logic signed [SIG_W-1:0] mr);
    int unsigned gap;
    gap = in_burst ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    desired_angle  <= da;
    measured_angle <= ma;
    measured_rate  <= mr;
    do @(posedge clk); while (!in_ready);
    drive_check.note_sample(da, ma, mr);
  endtask

  // Stop sending and wait until every predicted drive value has come out, so
  // that the core is idle before the registers change.
  task automatic settle();
    in_valid <= 1'b0;
    while (drive_check.pending() != 0) @(posedge clk);
  endtask

  // Program all eight registers for a phase. Limit writes carry a random top
  // bit that the core must mask off, and one write to an unused index must be
  // dropped without touching any register.
  task automatic configure(phase_kind_t kind);
    cfg_regs_t s;
    case (kind)
      PH_TYPICAL: begin
        s.angle_limit   = LIM_W'($urandom_range(0, 1 << 19));
        s.angle_p_gain  = near_sig(1 << 20);
        s.angle_ff_gain = near_sig(1 << 18);
        s.rate_limit    = LIM_W'($urandom_range(0, 1 << 20));
        s.rate_p_gain   = near_sig(1 << 17);
        s.rate_i_gain   = near_sig(1 << 10);
        s.rate_d_gain   = near_sig(1 << 15);
        s.rate_ff_gain  = near_sig(1 << 17);
      end
      PH_MAX: begin
        s.angle_limit   = LIM_TOP;
        s.angle_p_gain  = SIG_TOP;
        s.angle_ff_gain = SIG_TOP;
        s.rate_limit    = LIM_TOP;
        s.rate_p_gain   = SIG_TOP;
        s.rate_i_gain   = SIG_TOP;
        s.rate_d_gain   = SIG_TOP;
        s.rate_ff_gain  = SIG_TOP;
      end
      PH_MIN: begin
        s.angle_limit   = '0;
        s.angle_p_gain  = SIG_BOT;
        s.angle_ff_gain = SIG_BOT;
        s.rate_limit    = '0;
        s.rate_p_gain   = SIG_BOT;
        s.rate_i_gain   = SIG_BOT;
        s.rate_d_gain   = SIG_BOT;
        s.rate_ff_gain  = SIG_BOT;
      end
      PH_ZERO: s = '0;
      PH_PUSH_UP: begin
        // A large feedforward on a large command always hits the rate limit.
        s.angle_limit   = LIM_TOP;
        s.angle_p_gain  = '0;
        s.angle_ff_gain = SIG_TOP;
        s.rate_limit    = LIM_TOP;
        s.rate_p_gain   = near_sig(1 << 12);
        s.rate_i_gain   = near_sig(1 << 6);
        s.rate_d_gain   = near_sig(1 << 12);
        s.rate_ff_gain  = near_sig(1 << 12);
      end
      PH_PUSH_DOWN: begin
        // A large P gain on a large negative angle error saturates the demand low.
        s.angle_limit   = LIM_W'($urandom);
        s.angle_p_gain  = SIG_TOP;
        s.angle_ff_gain = '0;
        s.rate_limit    = LIM_W'($urandom);
        s.rate_p_gain   = near_sig(1 << 12);
        s.rate_i_gain   = near_sig(1 << 6);
        s.rate_d_gain   = near_sig(1 << 12);
        s.rate_ff_gain  = near_sig(1 << 12);
      end
      default: s = cfg_regs_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    endcase
    write_reg(REG_ANGLE_LIMIT,   {1'($urandom), s.angle_limit});
    write_reg(REG_ANGLE_P_GAIN,  s.angle_p_gain);
    write_reg(REG_ANGLE_FF_GAIN, s.angle_ff_gain);
    write_reg(IDX_W'($urandom_range(REG_COUNT, 2 ** IDX_W - 1)), any_sig());
    write_reg(REG_RATE_LIMIT,    {1'($urandom), s.rate_limit});
    write_reg(REG_RATE_P_GAIN,   s.rate_p_gain);
    write_reg(REG_RATE_I_GAIN,   s.rate_i_gain);
    write_reg(REG_RATE_D_GAIN,   s.rate_d_gain);
    write_reg(REG_RATE_FF_GAIN,  s.rate_ff_gain);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(phase_kind_t kind, int unsigned count);
    logic signed [SIG_W-1:0] da, ma, mr;
    repeat (count) begin
      case (kind)
        PH_TYPICAL: begin
          if ($urandom_range(0, 9) == 0) begin
            da = any_sig();
            ma = any_sig();
            mr = any_sig();
          end else begin
            da = near_sig(1 << 19);
            ma = near_sig(1 << 19);
            mr = near_sig(1 << 19);
          end
        end
        PH_PUSH_UP: begin
          da = between(1 << 22, SIG_TOP_I);
          ma = any_sig();
          mr = between(SIG_BOT_I, -(1 << 22));
        end
        PH_PUSH_DOWN: begin
          da = between(SIG_BOT_I, -(1 << 22));
          ma = between(1 << 22, SIG_TOP_I);
          mr = between(1 << 22, SIG_TOP_I);
        end
        default: begin
          da = any_sig();
          ma = any_sig();
          mr = any_sig();
        end
      endcase
      send_sample(da, ma, mr);
    end
  endtask

  initial begin : stimulus
    // The push-up phase runs long enough to drive the integrator into its upper
    // limit, and the push-down phase long enough to carry it to the lower one.
    phase_kind_t plan_kind[10] = '{PH_TYPICAL, PH_WIDE, PH_PUSH_UP, PH_TYPICAL,
                                   PH_PUSH_DOWN, PH_MAX, PH_MIN, PH_ZERO,
                                   PH_WIDE, PH_TYPICAL};
    int unsigned plan_len[10] = '{250, 120, 290, 150, 540, 60, 60, 30, 80, 120};
    logic signed [SIG_W-1:0] lim;

    drive_check = new();
    rst            <= 1'b1;
    in_valid       <= 1'b0;
    desired_angle  <= '0;
    measured_angle <= '0;
    measured_rate  <= '0;
    cfg_valid      <= 1'b0;
    cfg_index      <= '0;
    cfg_data       <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed samples at the reset register values.
    lim = SIG_W'(RST_ANGLE_LIMIT);
    send_sample('0, '0, '0);
    send_sample(SIG_TOP, SIG_TOP, SIG_TOP);
    send_sample(SIG_BOT, SIG_BOT, SIG_BOT);
    send_sample(SIG_TOP, SIG_BOT, SIG_BOT);
    // Demand far below the 24-bit range and a rate error below it as well.
    send_sample(SIG_BOT, SIG_TOP, SIG_TOP);
    send_sample(SIG_BOT, SIG_TOP, SIG_BOT);
    // Command exactly at the angle limit, then just above it.
    send_sample(lim, '0, '0);
    send_sample(lim + SIG_W'(1), '0, '0);
    // Large angle error: the rate demand hits its upper limit.
    send_sample(lim, -lim, '0);
    send_sample(SIG_W'(1), -SIG_W'(1), SIG_W'(1));
    send_sample(-SIG_W'(1), '0, SIG_BOT);
    send_sample('0, '0, SIG_TOP);
    send_sample(SIG_W'(24'h555555), SIG_W'(24'hAAAAAA), SIG_W'(24'h555555));
    send_sample(SIG_W'(24'hAAAAAA), SIG_W'(24'h555555), SIG_W'(24'hAAAAAA));
    // Repeated sample: the derivative term goes to zero.
    repeat (3) send_sample(SIG_W'(12345), SIG_W'(-6789), SIG_W'(2468));
    settle();

    foreach (plan_kind[p]) begin
      configure(plan_kind[p]);
      in_burst  = ($urandom_range(0, 3) == 0);
      out_burst = ($urandom_range(0, 3) == 0);
      run_phase(plan_kind[p], plan_len[p]);
      settle();
    end

    // Give the core time to show any result it should not produce.
    repeat (2 * ITEM_CYCLES) @(posedge clk);
    drive_check.close();
    if (drive_check.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/cap_pkg.sv
hw/rtl/cap_regs.sv
hw/rtl/cap_ctrl.sv
hw/rtl/cap_dp.sv
hw/rtl/cascaded_attitude_pid_axis_core.sv
hw/rtl/cap_checker.sv
sim/tb.sv
